// ===== src/wsld_pkg.sv =====
// ---------------------------------------------------------------------------
// wsld_pkg: shared types and constants for the weighing-scale line decoder
// Character codes, status codes, parse phases and the line summary record
// passed from the parser to the scaling stages.
// ---------------------------------------------------------------------------
package wsld_pkg;

  localparam int ACC_W      = 32;
  localparam int WEIGHT_W   = 32;
  localparam int FRAC_CNT_W = 3;   // holds up to six fraction digits
  localparam int POW10_W    = 20;  // 10^6 fits in 20 bits

  localparam logic [2:0] MIN_CONTENT = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_L     = 8'h4C;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NO_COMMA  = 3'd2,
    ST_OVERLOAD  = 3'd3,
    ST_NO_NUMBER = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_BLANK   = 3'd0,
    PH_SIGN    = 3'd1,
    PH_INT     = 3'd2,
    PH_FRAC    = 3'd3,
    PH_DONE    = 3'd4,
    PH_NOCOMMA = 3'd5
  } phase_t;

  typedef struct packed {
    status_t                 status;
    logic                    negative;
    logic                    clamp;
    logic [ACC_W-1:0]        acc;
    logic [FRAC_CNT_W-1:0]   frac_count;
  } line_sum_t;

  function automatic logic [POW10_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] k);
    logic [POW10_W-1:0] p;
    unique case (k)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== src/weigh_scale_line_decoder_top.sv =====
// ---------------------------------------------------------------------------
// weigh_scale_line_decoder_top: serial weighing-scale line decoder
// Parses scale lines byte by byte and emits status and fixed-point weight.
// ---------------------------------------------------------------------------
//  channel  | signals                                        | beat
//  ---------+------------------------------------------------+-----------------
//  input    | byte_valid, byte_ready, rx_byte                | one received byte
//  result   | result_valid, result_ready, status,            | one finished line
//           | weight_milli, saturated                        |
//
// One byte per cycle while byte_ready is high. A line feed's result passes
// through the parser summary register (loaded on the beat), the multiply
// register and the clamp/output register.
// byte_ready drops only when all three stages are full and the result side
// stalls. Reset (synchronous) empties the pipeline and clears the line state.
// ---------------------------------------------------------------------------
module weigh_scale_line_decoder_top #(
  parameter int LINE_LEN    = 32,
  parameter int FRAC_DIGITS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [2:0]                    status,
  output logic [wsld_pkg::WEIGHT_W-1:0] weight_milli,
  output logic                          saturated
);

  logic                sum_valid;
  logic                sum_take;
  wsld_pkg::line_sum_t sum;

  assign byte_ready = !sum_valid || sum_take;

  wsld_parser #(
    .LINE_LEN    (LINE_LEN),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .beat      (byte_valid && byte_ready),
    .rx_byte   (rx_byte),
    .sum_valid (sum_valid),
    .sum_take  (sum_take),
    .sum       (sum)
  );

  wsld_scale #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum_take     (sum_take),
    .sum          (sum),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .weight_milli (weight_milli),
    .saturated    (saturated)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != wsld_pkg::ST_OK |-> weight_milli == '0 && !saturated)
    else $error("non-ok result carries weight or saturation");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      weight_milli == 32'h7FFF_FFFF || weight_milli == 32'h8000_0000)
    else $error("saturated result not at a range limit");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> result_valid && !result_ready)
    else $error("input stalled without result back-pressure");

  a_ready_on_take: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready |-> byte_ready)
    else $error("input not ready while a result beat frees the pipeline");
`endif

endmodule

// ===== src/wsld_parser.sv =====
// ---------------------------------------------------------------------------
// wsld_parser: per-byte line parser
// Tracks the current line, accumulates the number after the comma and, on a
// line feed that closes a non-empty line, registers a line summary.
// ---------------------------------------------------------------------------
module wsld_parser #(
  parameter int LINE_LEN    = 32,
  parameter int FRAC_DIGITS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat,       // byte accepted this cycle
  input  logic [7:0]          rx_byte,
  output logic                sum_valid,
  input  logic                sum_take,
  output wsld_pkg::line_sum_t sum
);

  localparam int CNT_W = $clog2(LINE_LEN);

  logic [CNT_W-1:0]                char_count, char_count_next;
  logic [15:0]                     lead_chars, lead_chars_next;
  logic [2:0]                      content_len, content_len_next;  // saturates at five
  logic                            term_seen, term_seen_next;
  wsld_pkg::phase_t                phase, phase_next;
  logic                            negative, negative_next;
  logic [wsld_pkg::ACC_W-1:0]      acc, acc_next;
  logic [wsld_pkg::FRAC_CNT_W-1:0] frac_count, frac_count_next;
  logic                            digit_seen, digit_seen_next;
  logic                            clamp, clamp_next;

  logic                            line_end;
  logic                            is_digit;
  logic                            is_blank;
  logic [3:0]                      digit;
  logic [wsld_pkg::ACC_W+3:0]      acc_x10;
  logic                            acc_ovf;
  wsld_pkg::phase_t                ph_eff;
  wsld_pkg::status_t               status_now;

  assign is_digit = (rx_byte >= wsld_pkg::CH_ZERO) && (rx_byte <= wsld_pkg::CH_NINE);
  assign is_blank = (rx_byte == wsld_pkg::CH_SPACE) || (rx_byte == wsld_pkg::CH_TAB) ||
                    (rx_byte == wsld_pkg::CH_VT) || (rx_byte == wsld_pkg::CH_FF);
  assign digit    = 4'(rx_byte - wsld_pkg::CH_ZERO);

  // acc*10 + digit as shift-and-add, with headroom to spot overflow
  assign acc_x10 = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (wsld_pkg::ACC_W+4)'(digit);
  assign acc_ovf = |acc_x10[wsld_pkg::ACC_W+3:wsld_pkg::ACC_W];

  always_comb begin
    if (content_len < wsld_pkg::MIN_CONTENT) begin
      status_now = wsld_pkg::ST_SHORT;
    end else if (phase == wsld_pkg::PH_NOCOMMA) begin
      status_now = wsld_pkg::ST_NO_COMMA;
    end else if (lead_chars == {wsld_pkg::CH_O, wsld_pkg::CH_L}) begin
      status_now = wsld_pkg::ST_OVERLOAD;
    end else if (!digit_seen) begin
      status_now = wsld_pkg::ST_NO_NUMBER;
    end else begin
      status_now = wsld_pkg::ST_OK;
    end
  end

  always_comb begin
    char_count_next  = char_count;
    lead_chars_next  = lead_chars;
    content_len_next = content_len;
    term_seen_next   = term_seen;
    phase_next       = phase;
    negative_next    = negative;
    acc_next         = acc;
    frac_count_next  = frac_count;
    digit_seen_next  = digit_seen;
    clamp_next       = clamp;
    line_end         = 1'b0;
    ph_eff           = phase;

    if (beat && rx_byte != wsld_pkg::CH_CR) begin
      if (rx_byte == wsld_pkg::CH_LF ||
          char_count >= CNT_W'(LINE_LEN - 1)) begin
        // line feed closes the line; a byte into a full line discards it
        line_end         = (rx_byte == wsld_pkg::CH_LF) && (char_count != '0);
        char_count_next  = '0;
        lead_chars_next  = '0;
        content_len_next = '0;
        term_seen_next   = 1'b0;
        phase_next       = wsld_pkg::PH_BLANK;
        negative_next    = 1'b0;
        acc_next         = '0;
        frac_count_next  = '0;
        digit_seen_next  = 1'b0;
        clamp_next       = 1'b0;
      end else begin
        char_count_next = char_count + 1'b1;
        if (!term_seen) begin
          if (rx_byte == wsld_pkg::CH_NUL) begin
            term_seen_next = 1'b1;
          end else begin
            if (content_len < wsld_pkg::MIN_CONTENT) begin
              content_len_next = content_len + 1'b1;
            end
            if (char_count < CNT_W'(2)) begin
              lead_chars_next = {lead_chars[7:0], rx_byte};
            end else if (char_count == CNT_W'(2)) begin
              if (rx_byte != wsld_pkg::CH_COMMA) begin
                phase_next = wsld_pkg::PH_NOCOMMA;
              end
            end else if (phase != wsld_pkg::PH_NOCOMMA && phase != wsld_pkg::PH_DONE) begin
              if (phase == wsld_pkg::PH_BLANK) begin
                ph_eff = is_blank || rx_byte == wsld_pkg::CH_PLUS ||
                         rx_byte == wsld_pkg::CH_MINUS ? wsld_pkg::PH_BLANK
                                                       : wsld_pkg::PH_SIGN;
                if (rx_byte == wsld_pkg::CH_PLUS || rx_byte == wsld_pkg::CH_MINUS) begin
                  negative_next = (rx_byte == wsld_pkg::CH_MINUS);
                  phase_next    = wsld_pkg::PH_SIGN;
                end
              end
              if (ph_eff == wsld_pkg::PH_SIGN || ph_eff == wsld_pkg::PH_INT) begin
                if (is_digit) begin
                  acc_next        = acc_ovf ? '1 : acc_x10[wsld_pkg::ACC_W-1:0];
                  clamp_next      = clamp | acc_ovf;
                  digit_seen_next = 1'b1;
                  phase_next      = wsld_pkg::PH_INT;
                end else if (rx_byte == wsld_pkg::CH_POINT) begin
                  phase_next = wsld_pkg::PH_FRAC;
                end else begin
                  phase_next = wsld_pkg::PH_DONE;
                end
              end else if (ph_eff == wsld_pkg::PH_FRAC) begin
                if (is_digit) begin
                  digit_seen_next = 1'b1;
                  // digits past the kept precision are dropped: truncation
                  if (frac_count < wsld_pkg::FRAC_CNT_W'(FRAC_DIGITS)) begin
                    acc_next        = acc_ovf ? '1 : acc_x10[wsld_pkg::ACC_W-1:0];
                    clamp_next      = clamp | acc_ovf;
                    frac_count_next = frac_count + 1'b1;
                  end
                end else begin
                  phase_next = wsld_pkg::PH_DONE;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count  <= '0;
      lead_chars  <= '0;
      content_len <= '0;
      term_seen   <= 1'b0;
      phase       <= wsld_pkg::PH_BLANK;
      negative    <= 1'b0;
      acc         <= '0;
      frac_count  <= '0;
      digit_seen  <= 1'b0;
      clamp       <= 1'b0;
      sum_valid   <= 1'b0;
    end else begin
      char_count  <= char_count_next;
      lead_chars  <= lead_chars_next;
      content_len <= content_len_next;
      term_seen   <= term_seen_next;
      phase       <= phase_next;
      negative    <= negative_next;
      acc         <= acc_next;
      frac_count  <= frac_count_next;
      digit_seen  <= digit_seen_next;
      clamp       <= clamp_next;
      if (line_end) begin
        sum_valid <= 1'b1;
      end else if (sum_take) begin
        sum_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (line_end) begin
      sum.status     <= status_now;
      sum.negative   <= negative;
      sum.clamp      <= clamp;
      sum.acc        <= acc;
      sum.frac_count <= frac_count;
    end
  end

endmodule

// ===== src/wsld_scale.sv =====
// ---------------------------------------------------------------------------
// wsld_scale: fixed-point scaling and clamping of a line summary
// One stage multiplies by the missing power of ten, the next clamps to the
// signed 32-bit range, applies the sign and holds the result beat.
// ---------------------------------------------------------------------------
module wsld_scale #(
  parameter int FRAC_DIGITS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sum_valid,
  output logic                          sum_take,
  input  wsld_pkg::line_sum_t           sum,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [2:0]                    status,
  output logic [wsld_pkg::WEIGHT_W-1:0] weight_milli,
  output logic                          saturated
);

  localparam int SCALE_W = $clog2(10**FRAC_DIGITS + 1);
  localparam int PROD_W  = wsld_pkg::ACC_W + SCALE_W;

  logic                          mul_valid;
  wsld_pkg::status_t             mul_status;
  logic                          mul_neg;
  logic                          mul_clamp;
  logic [PROD_W-1:0]             mul_mag;

  logic                          mul_take;
  logic                          out_load;
  logic [SCALE_W-1:0]            scale;
  logic [PROD_W-1:0]             limit;
  logic                          over;
  logic [wsld_pkg::WEIGHT_W-1:0] weight_next;
  logic                          sat_next;

  assign out_load = mul_valid && (!result_valid || result_ready);
  assign mul_take = !mul_valid || out_load;
  assign sum_take = sum_valid && mul_take;

  assign scale = SCALE_W'(wsld_pkg::pow10(
                   wsld_pkg::FRAC_CNT_W'(FRAC_DIGITS) - sum.frac_count));

  // negative side reaches one further
  assign limit = mul_neg ? PROD_W'(33'h0_8000_0000) : PROD_W'(33'h0_7FFF_FFFF);
  assign over  = mul_clamp || (mul_mag > limit);

  always_comb begin
    if (mul_status != wsld_pkg::ST_OK) begin
      weight_next = '0;
      sat_next    = 1'b0;
    end else if (over) begin
      weight_next = mul_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sat_next    = 1'b1;
    end else begin
      weight_next = mul_neg ? (32'd0 - mul_mag[wsld_pkg::WEIGHT_W-1:0])
                            : mul_mag[wsld_pkg::WEIGHT_W-1:0];
      sat_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (mul_take) begin
        mul_valid <= sum_valid;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_take) begin
      mul_status <= sum.status;
      mul_neg    <= sum.negative;
      mul_clamp  <= sum.clamp;
      mul_mag    <= PROD_W'(sum.acc) * PROD_W'(scale);
    end
    if (out_load) begin
      status       <= mul_status;
      weight_milli <= weight_next;
      saturated    <= sat_next;
    end
  end

endmodule

// ===== tb/wsld_line_checker.sv =====
// ---------------------------------------------------------------------------
// wsld_line_checker: scoreboard for the weighing-scale line decoder
// Watches the byte and result channels. Each byte beat runs through a copy of
// the line parser, and every completed line queues its expected status, weight
// and clamp flag. Each result beat is compared with the oldest queued line.
// ---------------------------------------------------------------------------
module wsld_line_checker #(
  parameter int LINE_LEN    = 32,
  parameter int FRAC_DIGITS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  input  logic                          byte_ready,
  input  logic [7:0]                    rx_byte,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  logic [2:0]                    status,
  input  logic [wsld_pkg::WEIGHT_W-1:0] weight_milli,
  input  logic                          saturated,
  output int                            errors,
  output int                            outstanding
);

  typedef struct {
    wsld_pkg::status_t             status;
    logic [wsld_pkg::WEIGHT_W-1:0] weight;
    logic                          sat;
  } line_result_t;

  line_result_t expected_lines[$];
  line_result_t want;
  int           fails;

  // line state, cleared at every line end and every discard
  int unsigned       held;
  int unsigned       content_len;
  logic [15:0]       lead_pair;
  logic              nul_seen;
  wsld_pkg::phase_t  parse_state;
  logic              neg_sign;
  logic [31:0]       mag_acc;
  int unsigned       frac_kept;
  logic              any_digit;
  logic              acc_clamped;

  task automatic wipe_line();
    held        = 0;
    content_len = 0;
    lead_pair   = '0;
    nul_seen    = 1'b0;
    parse_state = wsld_pkg::PH_BLANK;
    neg_sign    = 1'b0;
    mag_acc     = '0;
    frac_kept   = 0;
    any_digit   = 1'b0;
    acc_clamped = 1'b0;
  endtask

  task automatic push_digit(input logic [7:0] ch);
    logic [63:0] t;
    t = {32'd0, mag_acc} * 64'd10 + {56'd0, ch - wsld_pkg::CH_ZERO};
    if (t > 64'hFFFF_FFFF) begin
      mag_acc     = '1;
      acc_clamped = 1'b1;
    end else begin
      mag_acc = t[31:0];
    end
    any_digit = 1'b1;
  endtask

  task automatic number_byte(input logic [7:0] ch);
    logic             is_digit;
    wsld_pkg::phase_t ph;
    is_digit = (ch >= wsld_pkg::CH_ZERO) && (ch <= wsld_pkg::CH_NINE);
    ph       = parse_state;
    if (ph == wsld_pkg::PH_BLANK) begin
      if (ch == wsld_pkg::CH_SPACE || ch == wsld_pkg::CH_TAB ||
          ch == wsld_pkg::CH_VT || ch == wsld_pkg::CH_FF)
        return;
      if (ch == wsld_pkg::CH_PLUS || ch == wsld_pkg::CH_MINUS) begin
        neg_sign    = (ch == wsld_pkg::CH_MINUS);
        parse_state = wsld_pkg::PH_SIGN;
        return;
      end
      ph = wsld_pkg::PH_SIGN;
    end
    if (ph == wsld_pkg::PH_SIGN || ph == wsld_pkg::PH_INT) begin
      if (is_digit) begin
        push_digit(ch);
        parse_state = wsld_pkg::PH_INT;
      end else if (ch == wsld_pkg::CH_POINT) begin
        parse_state = wsld_pkg::PH_FRAC;
      end else begin
        parse_state = wsld_pkg::PH_DONE;
      end
    end else if (ph == wsld_pkg::PH_FRAC) begin
      if (is_digit) begin
        any_digit = 1'b1;
        // digits past the kept precision only truncate
        if (frac_kept < FRAC_DIGITS) begin
          push_digit(ch);
          frac_kept++;
        end
      end else begin
        parse_state = wsld_pkg::PH_DONE;
      end
    end
  endtask

  task automatic close_line(output line_result_t r);
    logic [63:0] mag;
    logic [63:0] cap;
    int unsigned k;
    r.weight = '0;
    r.sat    = 1'b0;
    if (content_len < wsld_pkg::MIN_CONTENT)
      r.status = wsld_pkg::ST_SHORT;
    else if (parse_state == wsld_pkg::PH_NOCOMMA)
      r.status = wsld_pkg::ST_NO_COMMA;
    else if (lead_pair == {wsld_pkg::CH_O, wsld_pkg::CH_L})
      r.status = wsld_pkg::ST_OVERLOAD;
    else if (!any_digit)
      r.status = wsld_pkg::ST_NO_NUMBER;
    else begin
      r.status = wsld_pkg::ST_OK;
      mag      = {32'd0, mag_acc};
      cap      = neg_sign ? 64'h8000_0000 : 64'h7FFF_FFFF;
      for (k = frac_kept; k < FRAC_DIGITS; k++)
        mag = mag * 64'd10;
      if (acc_clamped || mag > cap) begin
        mag   = cap;
        r.sat = 1'b1;
      end
      r.weight = neg_sign ? -mag[31:0] : mag[31:0];
    end
  endtask

  task automatic absorb_byte(input logic [7:0] ch);
    int unsigned  pos;
    line_result_t r;
    if (ch == wsld_pkg::CH_CR)
      return;
    if (ch == wsld_pkg::CH_LF) begin
      if (held != 0) begin
        close_line(r);
        expected_lines.push_back(r);
      end
      wipe_line();
      return;
    end
    // buffer full: drop the byte and throw the line away
    if (held >= LINE_LEN - 1) begin
      wipe_line();
      return;
    end
    pos = held;
    held++;
    if (nul_seen)
      return;
    if (ch == wsld_pkg::CH_NUL) begin
      nul_seen = 1'b1;
      return;
    end
    content_len++;
    if (pos < 2)
      lead_pair = {lead_pair[7:0], ch};
    else if (pos == 2) begin
      if (ch != wsld_pkg::CH_COMMA)
        parse_state = wsld_pkg::PH_NOCOMMA;
    end else if (parse_state != wsld_pkg::PH_NOCOMMA && parse_state != wsld_pkg::PH_DONE)
      number_byte(ch);
  endtask

  initial wipe_line();

  always @(posedge clk) begin
    if (rst) begin
      wipe_line();
      expected_lines.delete();
    end else begin
      // a result never belongs to a byte taken on the same edge
      if (result_valid && result_ready) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: unexpected result beat: status %0d weight %0d saturated %0b",
                   $time, status, $signed(weight_milli), saturated);
          fails++;
        end else begin
          want = expected_lines.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
            fails++;
          end
          if (weight_milli !== want.weight) begin
            $display("%0t: weight_milli expected %0d, actual %0d", $time,
                     $signed(want.weight), $signed(weight_milli));
            fails++;
          end
          if (saturated !== want.sat) begin
            $display("%0t: saturated expected %0b, actual %0b", $time, want.sat, saturated);
            fails++;
          end
        end
      end
      if (byte_valid && byte_ready)
        absorb_byte(rx_byte);
    end
    errors      <= fails;
    outstanding <= expected_lines.size();
  end

endmodule

// ===== tb/weigh_scale_line_decoder_top_test.sv =====
// ---------------------------------------------------------------------------
// weigh_scale_line_decoder_top_test: line decoder testbench
// Feeds hand-picked scale lines covering each status and the corner cases,
// then a long run of random lines, mostly well formed with random content and
// the rest noise, short or over-long lines. Both channels stall at random.
// ---------------------------------------------------------------------------
module weigh_scale_line_decoder_top_test;

  localparam int LINE_LEN    = 32;
  localparam int FRAC_DIGITS = 3;
  localparam int BYTE_TARGET = 1100;

  logic                          clk;
  logic                          rst;
  logic                          byte_valid;
  logic                          byte_ready;
  logic [7:0]                    rx_byte;
  logic                          result_valid;
  logic                          result_ready;
  logic [2:0]                    status;
  logic [wsld_pkg::WEIGHT_W-1:0] weight_milli;
  logic                          saturated;
  int                            errors;
  int                            outstanding;

  logic steady;     // no stalls on either side while set
  int   bytes_sent;
  int   line_no;

  weigh_scale_line_decoder_top #(
    .LINE_LEN   (LINE_LEN),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .rx_byte     (rx_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status      (status),
    .weight_milli(weight_milli),
    .saturated   (saturated)
  );

  wsld_line_checker #(
    .LINE_LEN   (LINE_LEN),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .rx_byte     (rx_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status      (status),
    .weight_milli(weight_milli),
    .saturated   (saturated),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk)
    result_ready <= steady || ($urandom_range(99) >= 29);

  // called on a clock edge; returns on the edge that takes the beat
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 29) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    rx_byte    <= b;
    @(posedge clk);
    while (!byte_ready)
      @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      send_byte(s[i]);
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_byte(wsld_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  // hold the byte side until the decoder has handed back every line
  task automatic drain_lines();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
  endtask

  task automatic random_line();
    int          kind;
    int          pick;
    logic [7:0]  blanks[4];
    blanks = '{wsld_pkg::CH_SPACE, wsld_pkg::CH_TAB, wsld_pkg::CH_VT, wsld_pkg::CH_FF};
    kind   = $urandom_range(99);
    if (kind < 72) begin
      // well-formed line with random content
      if ($urandom_range(9) == 0)
        send_text("OL");
      else
        repeat (2) send_byte(8'($urandom_range(8'h41, 8'h5A)));
      if ($urandom_range(19) == 0)
        send_byte(8'($urandom_range(8'h21, 8'hFF)));
      else
        send_byte(wsld_pkg::CH_COMMA);
      repeat ($urandom_range(0, 2)) send_byte(blanks[$urandom_range(3)]);
      pick = $urandom_range(2);
      if (pick == 1)
        send_byte(wsld_pkg::CH_PLUS);
      else if (pick == 2)
        send_byte(wsld_pkg::CH_MINUS);
      if ($urandom_range(19) == 0) begin
        if ($urandom_range(1) != 0)
          send_text("inf");
        else
          send_text("nan");
      end else begin
        send_digits(($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5));
        if ($urandom_range(3) != 0) begin
          send_byte(wsld_pkg::CH_POINT);
          send_digits($urandom_range(0, 6));
        end
      end
      pick = $urandom_range(9);
      case (pick)
        0, 1, 2: send_text(" g");
        3:       send_text(" kg");
        4:       send_byte($urandom_range(1) ? "e" : "x");
        5: begin
          send_byte(wsld_pkg::CH_NUL);
          send_digits($urandom_range(0, 3));
        end
        default: ;
      endcase
      if ($urandom_range(3) == 0)
        send_byte(wsld_pkg::CH_CR);
    end else if (kind < 86) begin
      // raw noise across the whole byte range
      repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(255)));
    end else if (kind < 93) begin
      // usually runs past the line buffer
      send_text("ST,");
      repeat ($urandom_range(26, 38)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
    end else begin
      repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
    end
    send_byte(wsld_pkg::CH_LF);
  endtask

  initial begin
    rst          = 1'b1;
    byte_valid   = 1'b0;
    rx_byte      = '0;
    result_ready = 1'b0;
    steady       = 1'b0;
    bytes_sent   = 0;
    line_no      = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed lines
    send_byte(wsld_pkg::CH_LF);                               // empty line: nothing out
    send_text("ab"); send_byte(wsld_pkg::CH_LF);              // too short
    send_text("ST;1.0"); send_byte(wsld_pkg::CH_LF);          // no comma
    send_text("OL,+99"); send_byte(wsld_pkg::CH_LF);          // overload
    send_text("ST,"); send_byte(wsld_pkg::CH_SPACE); send_byte(wsld_pkg::CH_TAB);
    send_byte(wsld_pkg::CH_VT); send_byte(wsld_pkg::CH_FF);
    send_text("-12.3456"); send_byte(wsld_pkg::CH_CR); send_byte(wsld_pkg::CH_LF);
    send_text("ST,99999999999"); send_byte(wsld_pkg::CH_LF);  // accumulator clamps
    send_text("ST,-2147483.648"); send_byte(wsld_pkg::CH_LF); // most negative, exact
    send_text("ST,2147483.648"); send_byte(wsld_pkg::CH_LF);  // one past the top
    send_text("ST,inf"); send_byte(wsld_pkg::CH_LF);
    send_text("ST,1e5"); send_byte(wsld_pkg::CH_LF);
    send_text("ST,12"); send_byte(wsld_pkg::CH_NUL); send_text("99");
    send_byte(wsld_pkg::CH_LF);
    send_byte(wsld_pkg::CH_NUL); send_text("ST,5"); send_byte(wsld_pkg::CH_LF);
    send_byte(8'hFF); send_byte(8'h80); send_text(",5.5"); send_byte(wsld_pkg::CH_LF);
    send_text("ST,"); send_digits(28); send_byte("x"); send_byte(wsld_pkg::CH_LF);
    send_text("ST,7.5"); send_byte(wsld_pkg::CH_LF);
    drain_lines();

    while (bytes_sent < BYTE_TARGET) begin
      steady = (line_no >= 40 && line_no < 70);
      random_line();
      line_no++;
      if (line_no % 60 == 0)
        drain_lines();
    end
    steady = 1'b0;

    drain_lines();
    repeat (8) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2_400_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wsld_pkg.sv
src/wsld_parser.sv
src/wsld_scale.sv
src/weigh_scale_line_decoder_top.sv
tb/wsld_line_checker.sv
tb/weigh_scale_line_decoder_top_test.sv
